// ----- rtl/bf3i_pkg.sv -----
// Shared types, constants and helper functions for the inverted 3x3 box filter.
// No dependencies; bf3i_pos, bf3i_win and the top level import this package.
package bf3i_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int PIX_W       = 8;
  localparam int LINE_W      = 2 * PIX_W;
  localparam int WREG_W      = 11;
  localparam int HREG_W      = 13;
  localparam int SUM_W       = 12;
  localparam int DIV9_MUL    = 3641;   // ceil(2^15 / 9), exact for sums below 2^15
  localparam int DIV9_SHIFT  = 15;
  localparam int PROD_W      = SUM_W + $clog2(DIV9_MUL + 1);
  localparam int OUT_DATA_W  = 32;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int RST_WIDTH   = 640;
  localparam int RST_HEIGHT  = 480;
  localparam int MIN_DIM     = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // Output position and flags that travel with an item down the pipeline
  typedef struct packed {
    logic             emit;
    logic             border;
    logic             fend;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  // Clamp a width register value and return the index of the last column
  function automatic logic [COL_W-1:0] width_last(input logic [WREG_W-1:0] v);
    if (v < WREG_W'(MIN_DIM)) begin
      return COL_W'(MIN_DIM - 1);
    end else if (v > WREG_W'(MAX_WIDTH)) begin
      return COL_W'(MAX_WIDTH - 1);
    end else begin
      return COL_W'(v - WREG_W'(1));
    end
  endfunction

  // Clamp a height register value and return the index of the last row
  function automatic logic [ROW_W-1:0] height_last(input logic [HREG_W-1:0] v);
    if (v < HREG_W'(MIN_DIM)) begin
      return ROW_W'(MIN_DIM - 1);
    end else if (v > HREG_W'(MAX_HEIGHT)) begin
      return ROW_W'(MAX_HEIGHT - 1);
    end else begin
      return ROW_W'(v - HREG_W'(1));
    end
  endfunction

endpackage

// ----- rtl/bf3i_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bf3i_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bf3i_pos.sv -----
// Input and output position counters: priming, border and frame-end flags.
// Depends on bf3i_pkg.
module bf3i_pos (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      accept,
  input  logic [bf3i_pkg::COL_W-1:0] w_last,
  input  logic [bf3i_pkg::ROW_W-1:0] h_last,
  output bf3i_pkg::pos_t            pos,
  output logic [bf3i_pkg::COL_W-1:0] in_col
);
  import bf3i_pkg::*;

  localparam logic [1:0] ROWS_FULL = 2'd2;

  logic [COL_W-1:0] in_col_next;
  logic [1:0]       in_rows, in_rows_next;  // saturates once two rows are in
  logic [ROW_W-1:0] out_row, out_row_next;
  logic [COL_W-1:0] out_col, out_col_next;

  always_comb begin
    pos.emit   = (in_rows == ROWS_FULL) || ((in_rows == 2'd1) && (in_col != '0));
    pos.border = (out_row == '0) || (out_col == '0) ||
                 (out_row >= h_last) || (out_col >= w_last);
    pos.fend   = (out_row >= h_last) && (out_col >= w_last);
    pos.row    = out_row;
    pos.col    = out_col;
  end

  always_comb begin
    in_col_next  = in_col;
    in_rows_next = in_rows;
    out_row_next = out_row;
    out_col_next = out_col;
    if (clear) begin
      in_col_next  = '0;
      in_rows_next = '0;
      out_row_next = '0;
      out_col_next = '0;
    end else if (accept) begin
      if (in_col >= w_last) begin
        in_col_next = '0;
        if (in_rows != ROWS_FULL) begin
          in_rows_next = in_rows + 2'd1;
        end
      end else begin
        in_col_next = in_col + COL_W'(1);
      end
      if (pos.emit) begin
        if (pos.fend) begin
          in_col_next  = '0;
          in_rows_next = '0;
          out_row_next = '0;
          out_col_next = '0;
        end else if (out_col >= w_last) begin
          out_col_next = '0;
          out_row_next = out_row + ROW_W'(1);
        end else begin
          out_col_next = out_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_rows <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_col  <= in_col_next;
      in_rows <= in_rows_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

endmodule

// ----- rtl/bf3i_win.sv -----
// 3x3 window registers and the adder tree over the nine taps.
// Depends on bf3i_pkg.
module bf3i_win (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic [bf3i_pkg::PIX_W-1:0] top,
  input  logic [bf3i_pkg::PIX_W-1:0] mid,
  input  logic [bf3i_pkg::PIX_W-1:0] px,
  output logic [bf3i_pkg::SUM_W-1:0] sum
);
  import bf3i_pkg::*;

  localparam int ROWSUM_W = PIX_W + 2;

  // Row r holds taps 3r..3r+2, oldest row first, newest column last
  logic [PIX_W-1:0]    win [9];
  logic [ROWSUM_W-1:0] row_sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win[3*r]   <= win[3*r+1];
        win[3*r+1] <= win[3*r+2];
      end
      win[2] <= top;
      win[5] <= mid;
      win[8] <= px;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = ROWSUM_W'(win[3*r]) + ROWSUM_W'(win[3*r+1]) + ROWSUM_W'(win[3*r+2]);
    end
    sum = SUM_W'(row_sum[0]) + SUM_W'(row_sum[1]) + SUM_W'(row_sum[2]);
  end

endmodule

// ----- rtl/box_filter_3x3_inverted.sv -----
// Top level of the inverted 3x3 box filter: register port, line store, pipeline.
// Depends on bf3i_pkg, bf3i_ram, bf3i_pos and bf3i_win.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+----------------------------------------
//  s_*     | in        | s_tvalid / s_tready        | tdata: pixel_in; tuser: command
//  m_*     | out       | m_tvalid / m_tready        | tdata: pixel_out, out_row, out_col; tlast
//  APB     | in        | psel, penable, pwrite      | paddr 4*i: image_width, image_height
//
//  One item per clock is accepted while results are taken. An item goes through four
//  registered stages: input and line store read, window shift, 3x3 sum, divide-by-nine
//  and invert into the output register.
//  The read-modify-write of the line store sets the pace: one RAM port pair per item.
//  Reset clears control state and the window registers; the line store needs no clearing pass.
//  A stall on m_tready fills the stages behind it before s_tready drops.
module box_filter_3x3_inverted (
  input  logic                            clk,
  input  logic                            rst,
  // stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] pixel_in
  input  logic                            s_tuser,   // [0] command
  // stream out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [7:0] pixel_out, [19:8] out_row,
                                                     // [29:20] out_col, [31:30] zero
  output logic                            m_tlast,   // frame_end
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bf3i_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bf3i_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bf3i_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bf3i_pkg::*;

  // Register port ---------------------------------------------------------------------------
  logic              cfg_we;
  reg_idx_t          cfg_idx;
  logic [WREG_W-1:0] reg_width;
  logic [HREG_W-1:0] reg_height;
  logic [COL_W-1:0]  w_last;     // clamped width minus one
  logic [ROW_W-1:0]  h_last;     // clamped height minus one

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= WREG_W'(RST_WIDTH);
      reg_height <= HREG_W'(RST_HEIGHT);
      w_last     <= COL_W'(RST_WIDTH - 1);
      h_last     <= ROW_W'(RST_HEIGHT - 1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH: begin
          reg_width <= pwdata[WREG_W-1:0];
          w_last    <= width_last(pwdata[WREG_W-1:0]);
        end
        REG_HEIGHT: begin
          reg_height <= pwdata[HREG_W-1:0];
          h_last     <= height_last(pwdata[HREG_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = APB_DATA_W'(reg_width);
      REG_HEIGHT: prdata = APB_DATA_W'(reg_height);
      default:    prdata = '0;
    endcase
  end

  // Stage handshakes: a stage may load when empty or when it empties this cycle ------------
  logic accept;
  logic a_valid, b_valid, c_valid, o_valid;
  logic a_free, b_free, c_free, o_free;
  logic a_adv, b_adv, c_adv;

  assign o_free   = !o_valid || m_tready;
  assign c_free   = !c_valid || o_free;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign s_tready = a_free;
  assign accept   = s_tvalid && s_tready;
  assign a_adv    = a_valid && b_free;
  assign b_adv    = b_valid && c_free;
  assign c_adv    = c_valid && o_free;

  // Position counters -----------------------------------------------------------------------
  pos_t             in_pos;
  logic [COL_W-1:0] in_col;

  bf3i_pos u_pos (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_we),
    .accept (accept),
    .w_last (w_last),
    .h_last (h_last),
    .pos    (in_pos),
    .in_col (in_col)
  );

  // Stage A: input register and line store read --------------------------------------------
  logic              a_wr;       // write back the line store in the cycle after accept
  logic [PIX_W-1:0]  a_px;
  logic [COL_W-1:0]  a_col;
  pos_t              a_pos;
  logic [LINE_W-1:0] line_rd;    // [15:8] previous row, [7:0] row before it
  logic [PIX_W-1:0]  top, mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_wr    <= 1'b0;
    end else begin
      a_wr <= accept;
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // a flush acts as a zero pixel
      a_px  <= (cmd_t'(s_tuser) == CMD_FLUSH) ? '0 : s_tdata;
      a_col <= in_col;
      a_pos <= in_pos;
    end
  end

  assign top = line_rd[PIX_W-1:0];
  assign mid = line_rd[LINE_W-1:PIX_W];

  // Both line stores share one word: shift the previous row down, put the new pixel on top
  bf3i_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (a_wr),
    .waddr (a_col),
    .wdata ({a_px, mid}),
    .re    (accept),
    .raddr (in_col),
    .rdata (line_rd)
  );

  // Stage B: window; every item shifts it, only items with a result stay valid ---------------
  pos_t             b_pos;
  logic [SUM_W-1:0] win_sum;

  bf3i_win u_win (
    .clk   (clk),
    .rst   (rst),
    .shift (a_adv),
    .top   (top),
    .mid   (mid),
    .px    (a_px),
    .sum   (win_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv) begin
      b_valid <= a_pos.emit;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_pos <= a_pos;
    end
  end

  // Stage C: registered window sum ----------------------------------------------------------
  pos_t             c_pos;
  logic [SUM_W-1:0] c_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (b_adv) begin
      c_valid <= 1'b1;
    end else if (c_adv) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_pos <= b_pos;
      c_sum <= win_sum;
    end
  end

  // Output register: floor(sum / 9) by reciprocal multiply, then invert, border at zero --------
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  quot;
  logic [PIX_W-1:0]  o_pixel;
  logic [ROW_W-1:0]  o_row;
  logic [COL_W-1:0]  o_col;
  logic              o_fend;

  assign prod = PROD_W'(c_sum) * PROD_W'(DIV9_MUL);
  assign quot = prod[DIV9_SHIFT +: PIX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (c_adv) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      o_pixel <= c_pos.border ? '0 : PIX_MAX - quot;   // hold the border at zero
      o_row   <= c_pos.row;
      o_col   <= c_pos.col;
      o_fend  <= c_pos.fend;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = OUT_DATA_W'({o_col, o_row, o_pixel});
  assign m_tlast  = o_fend;

endmodule
